>>> rtl/drq_pkg.sv
// Shared types and constants for the deferred reclaim queue.
// No dependencies; imported by every module of the block.
package drq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int LAG_W           = 4;
  localparam int CMD_FIFO_DEPTH  = 2;
  localparam int CFG_ADDR_W      = 3;

  localparam logic [LAG_W-1:0]      LAG_RESET = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] ADDR_LAG  = 3'd0;

  typedef enum logic {
    MODE_SCHEDULE = 1'b0,
    MODE_BEGIN    = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_RECLAIM = 2'd1,
    KIND_NONE    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_COUNT,
    BK_EMIT
  } back_state_t;

  // Classified command from the front end; frame holds the completed
  // frame for a begin command and the submitted frame for a schedule.
  typedef struct packed {
    mode_t             mode;
    logic [DATA_W-1:0] handle;
    logic [DATA_W-1:0] frame;
  } cmd_t;

  // Result word, counts travel alongside as their width follows the depth
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [DATA_W-1:0] handle;
    logic [DATA_W-1:0] frame;
    logic              dropped;
    logic              last;
  } res_t;

endpackage

>>> rtl/drq_front.sv
// Front end: accepts input words, works out the completed frame for
// begin commands and holds them in a short command queue. Uses drq_pkg.
module drq_front
  import drq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              mode,
  input  logic [DATA_W-1:0] handle,
  input  logic [DATA_W-1:0] frame_number,
  input  logic [LAG_W-1:0]  lag,
  output logic              busy,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_pop
);

  localparam int PW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int FW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t           q_r [CMD_FIFO_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0]  cnt_r, cnt_nxt;
  cmd_t           cmd_in;
  logic           push, pop;
  logic [DATA_W-1:0] lag_ext;

  // Classify: saturate the completed frame at zero
  assign lag_ext = {{(DATA_W-LAG_W){1'b0}}, lag};

  always_comb begin
    cmd_in.mode   = mode_t'(mode);
    cmd_in.handle = handle;
    if (mode_t'(mode) == MODE_BEGIN) begin
      cmd_in.frame = (frame_number >= lag_ext) ? (frame_number - lag_ext) : '0;
    end else begin
      cmd_in.frame = frame_number;
    end
  end

  // Queue handshake
  assign busy      = (cnt_r == FW'(CMD_FIFO_DEPTH));
  assign push      = start & ~busy;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_pop & cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the classified word
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

>>> rtl/drq_back.sv
// Back end: entry memory, schedule append and the two-pass begin-frame
// sequencer (count, then emit and compact). Uses drq_pkg.
module drq_back
  import drq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  cmd_t          cmd,
  output logic          cmd_pop,
  output res_t          res,
  output logic [CW-1:0] res_run,
  output logic [CW-1:0] res_pending
);

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int ENT_W = 2 * DATA_W;

  back_state_t       state_r, state_nxt;
  logic [CW-1:0]     occ_r, occ_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [DATA_W-1:0] done_r, done_nxt;
  logic [CW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              pend_r, pend_nxt;
  logic [CW-1:0]     gone_r, gone_nxt;
  logic [CW-1:0]     keep_r, keep_nxt;
  logic [CW-1:0]     emit_r, emit_nxt;
  res_t              res_r, res_nxt;
  logic [CW-1:0]     run_r, run_nxt;
  logic [CW-1:0]     pcnt_r, pcnt_nxt;

  logic [ENT_W-1:0]  entry_mem [QUEUE_DEPTH];
  logic [ENT_W-1:0]  rdata_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;
  logic [DATA_W-1:0] rd_handle, rd_frame;
  logic              scan_done, issue, hit;

  assign rd_handle = rdata_r[ENT_W-1:DATA_W];
  assign rd_frame  = rdata_r[DATA_W-1:0];
  assign scan_done = (rd_idx_r == n_r) && !pend_r;
  assign issue     = (rd_idx_r != n_r);
  assign hit       = pend_r && (rd_frame <= done_r);

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= entry_mem[rd_idx_r[AW-1:0]];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && cmd.mode == MODE_BEGIN) begin
          state_nxt = BK_COUNT;
        end
      end
      BK_COUNT: begin
        if (scan_done) begin
          state_nxt = (gone_r == '0) ? BK_IDLE : BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (scan_done) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and result word
  always_comb begin
    occ_nxt    = occ_r;
    n_nxt      = n_r;
    done_nxt   = done_r;
    rd_idx_nxt = rd_idx_r;
    pend_nxt   = 1'b0;
    gone_nxt   = gone_r;
    keep_nxt   = keep_r;
    emit_nxt   = emit_r;
    res_nxt    = '0;
    run_nxt    = '0;
    pcnt_nxt   = pcnt_r;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = occ_r[AW-1:0];
    mem_wdata  = {cmd.handle, cmd.frame};
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.mode == MODE_SCHEDULE) begin
            // Append, or drop when full
            res_nxt.valid = 1'b1;
            res_nxt.kind  = KIND_ACK;
            res_nxt.last  = 1'b1;
            if (occ_r != CW'(QUEUE_DEPTH)) begin
              mem_we   = 1'b1;
              occ_nxt  = occ_r + 1'b1;
              pcnt_nxt = occ_r + 1'b1;
            end else begin
              res_nxt.dropped = 1'b1;
              pcnt_nxt        = occ_r;
            end
          end else begin
            n_nxt      = occ_r;
            done_nxt   = cmd.frame;
            rd_idx_nxt = '0;
            gone_nxt   = '0;
          end
        end
      end
      BK_COUNT: begin
        // First pass: count completed entries
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
          pend_nxt   = 1'b1;
        end
        if (hit) begin
          gone_nxt = gone_r + 1'b1;
        end
        if (scan_done) begin
          rd_idx_nxt = '0;
          keep_nxt   = '0;
          emit_nxt   = '0;
          if (gone_r == '0) begin
            res_nxt.valid = 1'b1;
            res_nxt.kind  = KIND_NONE;
            res_nxt.last  = 1'b1;
            pcnt_nxt      = n_r;
          end
        end
      end
      BK_EMIT: begin
        // Second pass: emit completed entries, compact survivors
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
          pend_nxt   = 1'b1;
        end
        if (hit) begin
          res_nxt.valid  = 1'b1;
          res_nxt.kind   = KIND_RECLAIM;
          res_nxt.handle = rd_handle;
          res_nxt.frame  = rd_frame;
          res_nxt.last   = ((emit_r + 1'b1) == gone_r);
          run_nxt        = gone_r;
          pcnt_nxt       = n_r - gone_r;
          emit_nxt       = emit_r + 1'b1;
        end else if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = keep_r[AW-1:0];
          mem_wdata = rdata_r;
          keep_nxt  = keep_r + 1'b1;
        end
        if (scan_done) begin
          occ_nxt = keep_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      occ_r    <= '0;
      pend_r   <= 1'b0;
      res_r    <= '0;
      rd_idx_r <= '0;
      n_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      pend_r   <= pend_nxt;
      res_r    <= res_nxt;
      rd_idx_r <= rd_idx_nxt;
      n_r      <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    done_r <= done_nxt;
    gone_r <= gone_nxt;
    keep_r <= keep_nxt;
    emit_r <= emit_nxt;
    run_r  <= run_nxt;
    pcnt_r <= pcnt_nxt;
  end

  assign res         = res_r;
  assign res_run     = run_r;
  assign res_pending = pcnt_r;

endmodule

>>> rtl/deferred_reclaim_queue_top.sv
// Top level of the deferred reclaim queue: configuration register port,
// front end and back end. Uses drq_pkg, drq_front and drq_back.
//
//   channel   handshake               payload
//   input     start / busy            in_mode, in_handle, in_frame_number
//   result    out_valid (strobe)      out_kind .. out_last
//   config    psel/penable/pwrite     paddr, pwdata, prdata (pready high)
//
// A schedule word passes the command queue, and its acknowledge leaves through
// the registered result word; back to back schedules sustain one per cycle
// through the queue while no begin word holds the back end. A begin word holds
// the back end while it reads the entry memory once to count and, unless
// nothing is reclaimed, once to emit and compact, one entry per cycle on its
// single read port.
// Reset (rst_n low, synchronous) empties the queue and sets the lag to 2.
// Results cannot be held off; busy rises only while the command queue is full.
module deferred_reclaim_queue_top
  import drq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_mode,
  input  logic [DATA_W-1:0]     in_handle,
  input  logic [DATA_W-1:0]     in_frame_number,
  output logic                  out_valid,
  output logic [1:0]            out_kind,
  output logic [DATA_W-1:0]     out_reclaimed_handle,
  output logic [DATA_W-1:0]     out_entry_frame,
  output logic [CW-1:0]         out_run_count,
  output logic [CW-1:0]         out_pending_count,
  output logic                  out_dropped,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [LAG_W-1:0] lag_r;
  logic             cfg_wr;
  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;
  res_t             res;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr == ADDR_LAG) ? {{(32-LAG_W){1'b0}}, lag_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_r <= LAG_RESET;
    end else if (cfg_wr && paddr == ADDR_LAG) begin
      lag_r <= pwdata[LAG_W-1:0];
    end
  end

  drq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .mode         (in_mode),
    .handle       (in_handle),
    .frame_number (in_frame_number),
    .lag          (lag_r),
    .busy         (busy),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  drq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .res         (res),
    .res_run     (out_run_count),
    .res_pending (out_pending_count)
  );

  // Unpack the result word
  assign out_valid            = res.valid;
  assign out_kind             = res.kind;
  assign out_reclaimed_handle = res.handle;
  assign out_entry_frame      = res.frame;
  assign out_dropped          = res.dropped;
  assign out_last             = res.last;

  // Checks
  a_run_only_on_reclaim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_RECLAIM |-> out_run_count == '0)
    else $error("run count set on a non-reclaim result");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pending_count <= CW'(QUEUE_DEPTH))
    else $error("pending count beyond queue depth");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |->
      out_kind == KIND_ACK && out_pending_count == CW'(QUEUE_DEPTH))
    else $error("drop flagged while queue not full");

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_NONE |-> out_last && out_run_count == '0)
    else $error("nothing-reclaimed result not final");

endmodule
